>>> src/dnsg_pkg.sv
// Shared constants, types and helper function of the diagonal net sampler.
`timescale 1ns / 1ps

package dnsg_pkg;

   // Default for the largest supported net size (log2 of the point count).
   localparam int unsigned MAX_BITS_DEF = 24;
   localparam int unsigned MIN_BITS     = 3;

   // Fixed field widths.
   localparam int unsigned INDEX_W    = 24;
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned SCALE_W    = 16;
   localparam int unsigned LIMIT_W    = 25;
   localparam int unsigned NET_BITS_W = 5;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned CSR_DATA_W = 25;
   localparam int unsigned CSR_IDX_W  = 2;

   // Register reset values.
   localparam logic [NET_BITS_W-1:0] NET_BITS_RST = NET_BITS_W'(8);
   localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(256);
   localparam logic [LIMIT_W-1:0]    LIMIT_RST    = LIMIT_W'(16777216);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NET_BITS     = 2'd0,
      CSR_OUTPUT_SCALE = 2'd1,
      CSR_SAMPLE_LIMIT = 2'd2
   } csr_index_type;

   // Shift amounts that follow from the net size.
   typedef struct packed {
      logic [SHIFT_W-1:0] m;
      logic [SHIFT_W-1:0] colbits;
      logic [SHIFT_W-1:0] dx;
      logic [SHIFT_W-1:0] dy;
      logic               odd;
   } geom_type;

   // Clamp the net size and derive the column width and diagonal shifts.
   function automatic geom_type net_geometry(logic [NET_BITS_W-1:0] net_bits,
                                             logic [SHIFT_W-1:0]    max_bits);
      geom_type         g;
      logic [SHIFT_W:0] m_inc;
      if (SHIFT_W'(net_bits) < SHIFT_W'(MIN_BITS)) begin
         g.m = SHIFT_W'(MIN_BITS);
      end else if (SHIFT_W'(net_bits) > max_bits) begin
         g.m = max_bits;
      end else begin
         g.m = SHIFT_W'(net_bits);
      end
      m_inc     = {1'b0, g.m} + (SHIFT_W+1)'(1);
      g.colbits = m_inc[SHIFT_W:1];
      g.odd     = g.m[0];
      g.dy      = g.m >> 1;
      g.dx      = g.odd ? (g.m >> 1) : ((g.m >> 1) - SHIFT_W'(2));
      return g;
   endfunction

endpackage

>>> src/dnsg_if.sv
// Request and response channel interfaces of the diagonal net sampler.
`timescale 1ns / 1ps

interface dnsg_req_if import dnsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

interface dnsg_rsp_if import dnsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;
   logic               in_range;

   modport source (output valid, output point_x, output point_y, output in_range,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input in_range,
                   output ready);
endinterface

>>> src/dnsg_index_split.sv
// First stage: range check and split of the index into row and column.
`timescale 1ns / 1ps

module dnsg_index_split import dnsg_pkg::*; #(
   parameter int unsigned MAX_BITS = MAX_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  geom_type                          geom,
   input  logic [LIMIT_W-1:0]                sample_limit,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [INDEX_W-1:0]                sample_index,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [MAX_BITS-1:0]               row_k,
   output logic [(MAX_BITS+1)/2-1:0]         col_j,
   output logic                              in_range
);

   localparam int unsigned HALF_W = (MAX_BITS + 1) / 2;
   localparam int unsigned WIDE_W = (MAX_BITS > INDEX_W) ? MAX_BITS : INDEX_W;

   logic                valid_ff;
   logic                adv;
   logic [WIDE_W-1:0]   idx_wide;
   logic [HALF_W-1:0]   col_mask;
   logic [MAX_BITS-1:0] row_in, row_ff;
   logic [HALF_W-1:0]   col_in, col_ff;
   logic                range_in, range_ff;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      idx_wide = WIDE_W'(sample_index);
      col_mask = ~({HALF_W{1'b1}} << geom.colbits);
      row_in   = MAX_BITS'(idx_wide >> geom.colbits);
      col_in   = HALF_W'(sample_index) & col_mask;
      range_in = ((idx_wide >> geom.m) == '0) &&
                 ({1'b0, sample_index} < sample_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         range_ff <= range_in;
      end
   end

   assign out_valid = valid_ff;
   assign row_k     = row_ff;
   assign col_j     = col_ff;
   assign in_range  = range_ff;

endmodule

>>> src/dnsg_coord_calc.sv
// Second and third stages: row offset by bit reversal and the diagonal sums.
`timescale 1ns / 1ps

module dnsg_coord_calc import dnsg_pkg::*; #(
   parameter int unsigned MAX_BITS = MAX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  geom_type                  geom,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [MAX_BITS-1:0]       row_k,
   input  logic [(MAX_BITS+1)/2-1:0] col_j,
   input  logic                      in_range,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [MAX_BITS-1:0]       coord_x,
   output logic [MAX_BITS-1:0]       coord_y,
   output logic                      out_in_range
);

   logic                v1_ff, v2_ff;
   logic                adv1, adv2;
   logic [MAX_BITS-1:0] rev_k;
   logic [MAX_BITS-1:0] col_w;
   logic [SHIFT_W-1:0]  rev_shift;
   logic [MAX_BITS-1:0] rev_in, rev_ff;
   logic [MAX_BITS-1:0] add_in, add_ff;
   logic [MAX_BITS-1:0] jx_in, jx_ff;
   logic [MAX_BITS-1:0] jy_in, jy_ff;
   logic [MAX_BITS-1:0] k_ff;
   logic                r1_ff;
   logic [MAX_BITS-1:0] net_mask;
   logic [MAX_BITS-1:0] x_in, x_ff;
   logic [MAX_BITS-1:0] y_in, y_ff;
   logic                r2_ff;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // Mirror the row across the full width, then drop to m bits.
   for (genvar i = 0; i < MAX_BITS; i++) begin : g_rev
      assign rev_k[i] = row_k[MAX_BITS-1-i];
   end

   always_comb begin
      col_w     = MAX_BITS'(col_j);
      rev_shift = SHIFT_W'(MAX_BITS) - geom.m;
      rev_in    = rev_k >> rev_shift;
      add_in    = geom.odd ? row_k
                           : (row_k >> 2) + (MAX_BITS'(1) << geom.dx);
      jx_in     = col_w << geom.dx;
      jy_in     = col_w << geom.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         rev_ff <= rev_in;
         add_ff <= add_in;
         jx_ff  <= jx_in;
         jy_ff  <= jy_in;
         k_ff   <= row_k;
         r1_ff  <= in_range;
      end
   end

   // Wrap both coordinates into the net.
   always_comb begin
      net_mask = ~({MAX_BITS{1'b1}} << geom.m);
      x_in     = (rev_ff + add_ff + jx_ff) & net_mask;
      y_in     = (k_ff + jy_ff) & net_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         r2_ff <= r1_ff;
      end
   end

   assign out_valid    = v2_ff;
   assign coord_x      = x_ff;
   assign coord_y      = y_ff;
   assign out_in_range = r2_ff;

endmodule

>>> src/dnsg_scale_mul.sv
// Fourth and fifth stages: scale multiply, shift by net size, output register.
`timescale 1ns / 1ps

module dnsg_scale_mul import dnsg_pkg::*; #(
   parameter int unsigned MAX_BITS = MAX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  geom_type            geom,
   input  logic [SCALE_W-1:0]  output_scale,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [MAX_BITS-1:0] coord_x,
   input  logic [MAX_BITS-1:0] coord_y,
   input  logic                in_range,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [COORD_W-1:0]  point_x,
   output logic [COORD_W-1:0]  point_y,
   output logic                point_in_range
);

   localparam int unsigned PROD_W = MAX_BITS + SCALE_W;

   logic               v1_ff, v2_ff;
   logic               adv1, adv2;
   logic [PROD_W-1:0]  px_in, px_ff;
   logic [PROD_W-1:0]  py_in, py_ff;
   logic               r1_ff;
   logic [COORD_W-1:0] ox_in, ox_ff;
   logic [COORD_W-1:0] oy_in, oy_ff;
   logic               r2_ff;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      px_in = PROD_W'(coord_x) * PROD_W'(output_scale);
      py_in = PROD_W'(coord_y) * PROD_W'(output_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         px_ff <= px_in;
         py_ff <= py_in;
         r1_ff <= in_range;
      end
   end

   // Drop the fraction; zero the point when the index was rejected.
   always_comb begin
      ox_in = r1_ff ? COORD_W'(px_ff >> geom.m) : '0;
      oy_in = r1_ff ? COORD_W'(py_ff >> geom.m) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         r2_ff <= r1_ff;
      end
   end

   assign out_valid      = v2_ff;
   assign point_x        = ox_ff;
   assign point_y        = oy_ff;
   assign point_in_range = r2_ff;

endmodule

>>> src/diagonal_net_sample_generator_core.sv
// Top level of the diagonal (0,m,2)-net sample generator.
`timescale 1ns / 1ps

// Maps each sample index word to one point of a diagonal (0,m,2)-net of 2^m
// points (m = net_bits held to 3..MAX_BITS), scaled so that the unit square
// spans output_scale grid steps; each coordinate is floor(c * scale / 2^m).
// The index splits into a row (high bits) and a column (low ceil(m/2) bits);
// the row offset is the m-bit bit reversal of the row plus a diagonal term
// that depends on whether m is odd or even. Indices at or past
// min(2^m, sample_limit) return in_range = 0 with both coordinates zero.
// Throughput is one word per clock while responses are taken. The pipeline
// has five register stages (index split, reversal and shifts, modular sums,
// scale multiply, final shift): the request edge loads the first stage, and
// each stage passes the word on to the next, up to the response register.
// Each stage holds its word when the stage after it is full and stalled, and
// an empty stage fills even while the response waits, so bubbles close up
// under backpressure. Write the registers only while no word is in flight.

module diagonal_net_sample_generator_core import dnsg_pkg::*; #(
   parameter int unsigned MAX_BITS = MAX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dnsg_req_if.sink              req_word,
   dnsg_rsp_if.source            rsp_word,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int unsigned HALF_W = (MAX_BITS + 1) / 2;

   // Configuration registers.
   logic [NET_BITS_W-1:0] net_bits_ff, net_bits_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;

   // Shift amounts decoded once from net_bits, shared by every stage.
   geom_type geom_ff, geom_in;

   // Stage links.
   logic                s1_valid, s1_ready;
   logic [MAX_BITS-1:0] s1_row;
   logic [HALF_W-1:0]   s1_col;
   logic                s1_range;
   logic                s3_valid, s3_ready;
   logic [MAX_BITS-1:0] s3_x, s3_y;
   logic                s3_range;

   // Decode the write; ignore unknown indices.
   always_comb begin
      net_bits_in = net_bits_ff;
      scale_in    = scale_ff;
      limit_in    = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NET_BITS:     net_bits_in = NET_BITS_W'(csr_write_data);
            CSR_OUTPUT_SCALE: scale_in    = SCALE_W'(csr_write_data);
            CSR_SAMPLE_LIMIT: limit_in    = LIMIT_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         net_bits_ff <= NET_BITS_RST;
         scale_ff    <= SCALE_RST;
         limit_ff    <= LIMIT_RST;
      end else begin
         net_bits_ff <= net_bits_in;
         scale_ff    <= scale_in;
         limit_ff    <= limit_in;
      end
   end

   // Decode from the register input so a word right after a write sees it.
   assign geom_in = net_geometry(net_bits_in, SHIFT_W'(MAX_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= net_geometry(NET_BITS_RST, SHIFT_W'(MAX_BITS));
      end else begin
         geom_ff <= geom_in;
      end
   end

   dnsg_index_split #(
      .MAX_BITS (MAX_BITS)
   ) u_split (
      .clock        (clock),
      .reset        (reset),
      .geom         (geom_ff),
      .sample_limit (limit_ff),
      .in_valid     (req_word.valid),
      .in_ready     (req_word.ready),
      .sample_index (req_word.sample_index),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .row_k        (s1_row),
      .col_j        (s1_col),
      .in_range     (s1_range)
   );

   dnsg_coord_calc #(
      .MAX_BITS (MAX_BITS)
   ) u_coord (
      .clock        (clock),
      .reset        (reset),
      .geom         (geom_ff),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .row_k        (s1_row),
      .col_j        (s1_col),
      .in_range     (s1_range),
      .out_valid    (s3_valid),
      .out_ready    (s3_ready),
      .coord_x      (s3_x),
      .coord_y      (s3_y),
      .out_in_range (s3_range)
   );

   dnsg_scale_mul #(
      .MAX_BITS (MAX_BITS)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .geom           (geom_ff),
      .output_scale   (scale_ff),
      .in_valid       (s3_valid),
      .in_ready       (s3_ready),
      .coord_x        (s3_x),
      .coord_y        (s3_y),
      .in_range       (s3_range),
      .out_valid      (rsp_word.valid),
      .out_ready      (rsp_word.ready),
      .point_x        (rsp_word.point_x),
      .point_y        (rsp_word.point_y),
      .point_in_range (rsp_word.in_range)
   );

   // A rejected index must come out as the origin.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_word.valid && !rsp_word.in_range) |->
         (rsp_word.point_x == '0) && (rsp_word.point_y == '0))
      else $error("out-of-range word carries a nonzero point");

   // Decoded net size stays clamped and tracks the register.
   assert property (@(posedge clock) disable iff (reset)
      (geom_ff.m >= SHIFT_W'(MIN_BITS)) && (geom_ff.m <= SHIFT_W'(MAX_BITS)) &&
      (geom_ff == net_geometry(net_bits_ff, SHIFT_W'(MAX_BITS))))
      else $error("net geometry out of step with net_bits");

   // Diagonal shifts: equal for odd m, two apart for even m.
   assert property (@(posedge clock) disable iff (reset)
      geom_ff.odd ? (geom_ff.dx == geom_ff.dy)
                  : (geom_ff.dy == geom_ff.dx + SHIFT_W'(2)))
      else $error("diagonal shifts inconsistent with net parity");

endmodule

>>> tb/diagonal_net_sample_generator_core_test.sv
// Self-checking testbench for the diagonal net sample generator core.
`timescale 1ns / 1ps

module diagonal_net_sample_generator_core_test;
   import dnsg_pkg::*;

   // The fourth register slot decodes to nothing; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = CSR_IDX_W'(3);
   localparam int unsigned NET_MAX    = MAX_BITS_DEF;
   localparam int unsigned LIMIT      = 400000;
   localparam int unsigned PHASES     = 12;
   localparam int unsigned PHASE_SIZE = 85;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               in_range;
   } net_point_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   dnsg_req_if req_word ();
   dnsg_rsp_if rsp_word ();

   // Shadow copy of the block's registers, updated as each write is issued.
   logic [NET_BITS_W-1:0] net_bits_reg = NET_BITS_RST;
   logic [SCALE_W-1:0]    scale_reg    = SCALE_RST;
   logic [LIMIT_W-1:0]    limit_reg    = LIMIT_RST;

   logic [INDEX_W-1:0] index_queue[$];   // sample indices not yet offered
   net_point_type      point_queue[$];   // points owed by the block, oldest first
   int unsigned        idle_pct = 35;
   int unsigned        failures = 0;

   diagonal_net_sample_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_word         (req_word),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hold the net size to the range the offset rule supports.
   function automatic int unsigned net_size(logic [NET_BITS_W-1:0] nb);
      if (nb < NET_BITS_W'(MIN_BITS)) begin
         return MIN_BITS;
      end
      if (nb > NET_BITS_W'(NET_MAX)) begin
         return NET_MAX;
      end
      return int'(nb);
   endfunction

   // First index that is out of range: min(2^m, sample_limit).
   function automatic logic [63:0] point_bound();
      logic [63:0] n;
      n = 64'd1 << net_size(net_bits_reg);
      return (n < 64'(limit_reg)) ? n : 64'(limit_reg);
   endfunction

   // Compute the scaled net point that the block owes for one index.
   function automatic net_point_type net_point(logic [INDEX_W-1:0] idx);
      net_point_type p;
      int unsigned   m, colbits, dx, dy;
      logic [31:0]   k, j, rev, offset;
      logic [63:0]   mask, xs, ys;
      p = '0;
      if (64'(idx) >= point_bound()) begin
         return p;
      end
      m       = net_size(net_bits_reg);
      colbits = (m + 1) >> 1;
      k       = 32'(idx >> colbits);
      j       = 32'(idx) & ((32'd1 << colbits) - 32'd1);
      // Row offset starts from the m-bit reversal of the row.
      for (int b = 0; b < 32; b++) begin
         rev[31-b] = k[b];
      end
      offset = rev >> (32 - m);
      dy     = m >> 1;
      if (m[0]) begin
         dx     = m >> 1;
         offset = offset + k;
      end else begin
         dx     = (m >> 1) - 2;
         offset = offset + (k >> 2) + (32'd1 << dx);
      end
      mask       = (64'd1 << m) - 64'd1;
      xs         = ((64'(offset) + (64'(j) << dx)) & mask) * 64'(scale_reg);
      ys         = ((64'(k) + (64'(j) << dy)) & mask) * 64'(scale_reg);
      p.x        = COORD_W'(xs >> m);
      p.y        = COORD_W'(ys >> m);
      p.in_range = 1'b1;
      return p;
   endfunction

   task automatic report(string field, int unsigned want, int unsigned got);
      failures++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
   endtask

   // Issue one register write and mirror it into the shadow copy.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_NET_BITS:     net_bits_reg = data[NET_BITS_W-1:0];
         CSR_OUTPUT_SCALE: scale_reg    = data[SCALE_W-1:0];
         CSR_SAMPLE_LIMIT: limit_reg    = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Write all three registers, with junk in the unused upper data bits, and poke the spare index on request.
   task automatic program_net(logic [NET_BITS_W-1:0] nb, logic [SCALE_W-1:0] scale,
                              logic [LIMIT_W-1:0] lim, bit poke_spare);
      write_reg(CSR_NET_BITS, {(CSR_DATA_W-NET_BITS_W)'($urandom), nb});
      write_reg(CSR_OUTPUT_SCALE, {(CSR_DATA_W-SCALE_W)'($urandom), scale});
      write_reg(CSR_SAMPLE_LIMIT, lim);
      if (poke_spare) begin
         write_reg(CSR_SPARE_INDEX, '1);
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until nothing is queued, offered or owed; every word yields a point,
   // so the block is empty once the last point has come back. Look at the
   // falling edge, when the driver's and monitor's updates have all landed.
   task automatic settle();
      @(negedge clock);
      while (index_queue.size() != 0 || req_word.valid || point_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: record the expected point on each accepted word, then
   // advance to the next queued index or idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_word.valid <= 1'b0;
      end else begin
         if (req_word.valid && req_word.ready) begin
            point_queue.push_back(net_point(req_word.sample_index));
         end
         if (!req_word.valid || req_word.ready) begin
            if (index_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_word.valid        <= 1'b1;
               req_word.sample_index <= index_queue.pop_front();
            end else begin
               req_word.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted word against the oldest expected
   // point, and stall the block at random.
   always @(posedge clock) begin
      net_point_type want;
      if (reset) begin
         rsp_word.ready <= 1'b0;
      end else begin
         if (rsp_word.valid && rsp_word.ready) begin
            if (point_queue.size() == 0) begin
               failures++;
               $display("%0t: unexpected point: expected none, got x=%0d y=%0d in_range=%0b",
                        $time, rsp_word.point_x, rsp_word.point_y, rsp_word.in_range);
            end else begin
               want = point_queue.pop_front();
               if (rsp_word.point_x !== want.x) begin
                  report("point_x", want.x, rsp_word.point_x);
               end
               if (rsp_word.point_y !== want.y) begin
                  report("point_y", want.y, rsp_word.point_y);
               end
               if (rsp_word.in_range !== want.in_range) begin
                  report("in_range", want.in_range, rsp_word.in_range);
               end
            end
         end
         rsp_word.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [NET_BITS_W-1:0] nb;
      logic [SCALE_W-1:0]    scale;
      logic [LIMIT_W-1:0]    lim;
      logic [63:0]           bound;
      int unsigned           m, r;

      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_NET_BITS;
      csr_write_data        = '0;
      req_word.valid        = 1'b0;
      req_word.sample_index = '0;
      rsp_word.ready        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings (m = 8): column edges, last in-range index, first
      // out-of-range index and the top of the index field.
      index_queue = '{24'h000000, 24'h000001, 24'h00000F, 24'h000010, 24'h0000AA,
                      24'h000055, 24'h0000FF, 24'h000100, 24'hFFFFFF, 24'h800000};
      settle();

      // Small net size: zero is held to 3, so eight points only.
      program_net(NET_BITS_W'(0), SCALE_W'(65535), '1, 1'b0);
      index_queue = '{24'h000000, 24'h000003, 24'h000004, 24'h000007, 24'h000008,
                      24'h7FFFFF};
      settle();

      // Large net size: 31 is held to the maximum; spare index write must be ignored.
      program_net(NET_BITS_W'(31), SCALE_W'(65535), '1, 1'b1);
      index_queue = '{24'h000000, 24'hFFFFFF, 24'hF0F0F0, 24'h0F0F0F};
      settle();

      // Smallest even net with the limit below the point count.
      program_net(NET_BITS_W'(4), SCALE_W'(65535), LIMIT_W'(5), 1'b0);
      index_queue = '{24'h000004, 24'h000005, 24'h000000};
      settle();

      // Zero limit rejects everything; zero scale.
      program_net(NET_BITS_W'(5), SCALE_W'(0), LIMIT_W'(0), 1'b0);
      index_queue = '{24'h000000, 24'h000001};
      settle();

      // Random phases: fresh settings each time, mostly in-range indices.
      for (int phase = 0; phase < PHASES; phase++) begin
         r = $urandom_range(9);
         if (r == 0) begin
            nb = NET_BITS_W'($urandom_range(2));
         end else if (r == 1) begin
            nb = NET_BITS_W'($urandom_range(31, NET_MAX + 1));
         end else begin
            nb = NET_BITS_W'($urandom_range(NET_MAX, MIN_BITS));
         end
         m = net_size(nb);
         r = $urandom_range(9);
         scale = (r == 0) ? SCALE_W'(0) : (r == 1) ? SCALE_W'(65535) : SCALE_W'($urandom);
         r = $urandom_range(19);
         if (r == 0) begin
            lim = '0;
         end else if (r < 5) begin
            lim = '1;
         end else if (r < 8) begin
            lim = LIMIT_W'(1 << 24);
         end else begin
            lim = LIMIT_W'($urandom_range((1 << m) + (1 << (m - 1)), 0));
         end
         // Drop idling on both sides for a long middle stretch.
         idle_pct = (phase == 5 || phase == 6) ? 0 : 35;
         program_net(nb, scale, lim, phase == 3);
         bound = point_bound();
         for (int n = 0; n < PHASE_SIZE; n++) begin
            r = $urandom_range(99);
            if (bound != 0 && r < 75) begin
               index_queue.push_back(INDEX_W'($urandom_range(32'(bound - 1), 0)));
            end else if (bound != 0 && r < 85) begin
               index_queue.push_back(INDEX_W'(r[0] ? bound : bound - 1));
            end else begin
               index_queue.push_back(INDEX_W'($urandom));
            end
         end
         settle();
      end

      // Drain: let the pipeline run on before the verdict.
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
